[hw/rtl/ede_pkg.sv]
// ============================================================================
// Edit distance engine package
// Shared constants, item types and helper functions for the edit distance
// engine.
// ============================================================================
package ede_pkg;

  // Store capacity and field widths.
  localparam int MAX_LEN   = 64;
  localparam int CHAR_BITS = 21;
  localparam int ADDR_W    = $clog2(MAX_LEN);
  localparam int CNT_W     = $clog2(MAX_LEN + 1);
  localparam int DIST_W    = 7;
  localparam int CMD_W     = 2;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_SRC     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TGT     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP     = 2'd3;

  // Input item.
  typedef struct packed {
    logic [CMD_W-1:0]     command;
    logic [CHAR_BITS-1:0] char_code;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              overflow;
  } out_item_t;

  // Control handed from the sequencer to the row unit.
  typedef struct packed {
    logic              issue;
    logic [ADDR_W-1:0] col;
    logic              first_row;
    logic              row_start;
    logic [ADDR_W-1:0] row_idx;
  } row_ctl_t;

  // Smallest of three distances.
  function automatic logic [DIST_W-1:0] min3(input logic [DIST_W-1:0] a,
                                             input logic [DIST_W-1:0] b,
                                             input logic [DIST_W-1:0] c);
    logic [DIST_W-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

endpackage

[hw/rtl/ede_row_unit.sv]
// ============================================================================
// Edit distance row unit
// Holds the dynamic-programming row in a synchronous memory and evaluates one
// cell per cycle while cells are issued: read the old entry, take the minimum, write it back.
// ============================================================================
module ede_row_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  ede_pkg::row_ctl_t                   ctl,
  input  logic [ede_pkg::CHAR_BITS-1:0]       src_char,
  input  logic [ede_pkg::CHAR_BITS-1:0]       tgt_char,
  output logic [ede_pkg::DIST_W-1:0]          cur
);

  // Row memory: entry k holds column k+1 of the previous row.
  logic [ede_pkg::DIST_W-1:0] row_mem [ede_pkg::MAX_LEN];
  logic [ede_pkg::DIST_W-1:0] row_q;

  // Compute stage registers.
  logic                       cell_v;
  logic [ede_pkg::ADDR_W-1:0] cell_col;
  logic                       cell_first;
  logic [ede_pkg::DIST_W-1:0] left;
  logic [ede_pkg::DIST_W-1:0] diag;

  logic [ede_pkg::DIST_W-1:0] up;
  logic [ede_pkg::DIST_W-1:0] diag_cost;

  // Stage valid follows the read issue in the next cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_v <= 1'b0;
    end else begin
      cell_v <= ctl.issue;
    end
  end

  // Column and row flags travel with the read.
  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      cell_col   <= ctl.col;
      cell_first <= ctl.first_row;
    end
  end

  // Registered read of the previous row.
  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      row_q <= row_mem[ctl.col];
    end
  end

  // In the first row the previous row is the column index itself.
  always_comb begin
    up        = cell_first ? ({1'b0, cell_col} + ede_pkg::DIST_W'(1)) : row_q;
    diag_cost = diag + ede_pkg::DIST_W'(src_char != tgt_char);
    cur       = ede_pkg::min3(left + ede_pkg::DIST_W'(1),
                              up + ede_pkg::DIST_W'(1),
                              diag_cost);
  end

  // Write the new cell back in place of the one just read.
  always_ff @(posedge clk) begin
    if (cell_v) begin
      row_mem[cell_col] <= cur;
    end
  end

  // Left and diagonal neighbors; a row start seeds them with the row index.
  always_ff @(posedge clk) begin
    if (ctl.row_start) begin
      left <= {1'b0, ctl.row_idx} + ede_pkg::DIST_W'(1);
      diag <= {1'b0, ctl.row_idx};
    end else if (cell_v) begin
      left <= cur;
      diag <= up;
    end
  end

endmodule

[hw/rtl/edit_distance_engine_core.sv]
// ============================================================================
// Edit distance engine
// Loads a source and a target string one character per item and, on a
// compute item, returns their Levenshtein distance and a truncation flag.
// ============================================================================
//
//   channel | signals                       | moves
//   --------+-------------------------------+------------------------------
//   in      | in_valid, in_ready, in_item   | command and character code
//   out     | out_valid, out_ready, out_item| distance and overflow flag
//
// A compute item walks the source rows in order: a row setup step, then one
// step per target cell, with the row memory read and written once per cell,
// and a drain and a finish step at the end; an empty string goes straight to finish.
// Reset clears the lengths, the overflow flag and the output register.
// The block takes no item while computing or while a finished result waits
// for the output register; loads are taken while a result waits.
module edit_distance_engine_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ede_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output ede_pkg::out_item_t out_item
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ROW    = 3'd1;
  localparam logic [2:0] S_CELL   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]                    state;
  logic [ede_pkg::CNT_W-1:0]     src_cnt;
  logic [ede_pkg::CNT_W-1:0]     tgt_cnt;
  logic                          ovf_seen;
  logic [ede_pkg::ADDR_W-1:0]    row_i;
  logic [ede_pkg::ADDR_W-1:0]    col;
  logic [ede_pkg::DIST_W-1:0]    res_dist;

  // Character stores and their registered read data.
  logic [ede_pkg::CHAR_BITS-1:0] src_mem [ede_pkg::MAX_LEN];
  logic [ede_pkg::CHAR_BITS-1:0] tgt_mem [ede_pkg::MAX_LEN];
  logic [ede_pkg::CHAR_BITS-1:0] src_q;
  logic [ede_pkg::CHAR_BITS-1:0] tgt_q;

  logic                          in_fire;
  logic                          src_room;
  logic                          tgt_room;
  logic                          last_col;
  logic                          last_row;
  ede_pkg::row_ctl_t             ctl;
  logic [ede_pkg::DIST_W-1:0]    cur;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign src_room = (src_cnt < ede_pkg::CNT_W'(ede_pkg::MAX_LEN));
  assign tgt_room = (tgt_cnt < ede_pkg::CNT_W'(ede_pkg::MAX_LEN));
  assign last_col = ({1'b0, col} == (tgt_cnt - ede_pkg::CNT_W'(1)));
  assign last_row = ({1'b0, row_i} == (src_cnt - ede_pkg::CNT_W'(1)));

  // Control for the row unit.
  always_comb begin
    ctl.issue     = (state == S_CELL);
    ctl.col       = col;
    ctl.first_row = (row_i == '0);
    ctl.row_start = (state == S_ROW);
    ctl.row_idx   = row_i;
  end

  // Sequencer, lengths, overflow flag and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      src_cnt   <= '0;
      tgt_cnt   <= '0;
      ovf_seen  <= 1'b0;
      out_valid <= 1'b0;
      row_i     <= '0;
      col       <= '0;
    end else begin
      // A taken result frees the output register unless the finish step refills it.
      if (out_valid && out_ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            unique case (in_item.command)
              ede_pkg::CMD_SRC: begin
                if (src_room) src_cnt <= src_cnt + ede_pkg::CNT_W'(1);
                else          ovf_seen <= 1'b1;
              end
              ede_pkg::CMD_TGT: begin
                if (tgt_room) tgt_cnt <= tgt_cnt + ede_pkg::CNT_W'(1);
                else          ovf_seen <= 1'b1;
              end
              ede_pkg::CMD_COMPUTE: begin
                // An empty string gives the other string's length.
                if (src_cnt == '0 || tgt_cnt == '0) begin
                  res_dist <= ede_pkg::DIST_W'(src_cnt + tgt_cnt);
                  state    <= S_FINISH;
                end else begin
                  row_i <= '0;
                  state <= S_ROW;
                end
              end
              ede_pkg::CMD_NOP: begin
              end
              default: begin
              end
            endcase
          end
        end
        S_ROW: begin
          col   <= '0;
          state <= S_CELL;
        end
        S_CELL: begin
          if (last_col) begin
            if (last_row) begin
              state <= S_DRAIN;
            end else begin
              row_i <= row_i + ede_pkg::ADDR_W'(1);
              state <= S_ROW;
            end
          end else begin
            col <= col + ede_pkg::ADDR_W'(1);
          end
        end
        S_DRAIN: begin
          // The last cell of the last row is in the compute stage now.
          res_dist <= cur;
          state    <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid         <= 1'b1;
            out_item.distance <= res_dist;
            out_item.overflow <= ovf_seen;
            src_cnt           <= '0;
            tgt_cnt           <= '0;
            ovf_seen          <= 1'b0;
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Source store: append on load, read once per row.
  always_ff @(posedge clk) begin
    if (in_fire && in_item.command == ede_pkg::CMD_SRC && src_room) begin
      src_mem[src_cnt[ede_pkg::ADDR_W-1:0]] <= in_item.char_code;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_ROW) begin
      src_q <= src_mem[row_i];
    end
  end

  // Target store: append on load, read once per cell.
  always_ff @(posedge clk) begin
    if (in_fire && in_item.command == ede_pkg::CMD_TGT && tgt_room) begin
      tgt_mem[tgt_cnt[ede_pkg::ADDR_W-1:0]] <= in_item.char_code;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CELL) begin
      tgt_q <= tgt_mem[col];
    end
  end

  // Row memory and cell arithmetic.
  ede_row_unit u_row (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .src_char (src_q),
    .tgt_char (tgt_q),
    .cur      (cur)
  );

endmodule

[hw/rtl/ede_checker.sv]
// ============================================================================
// Edit distance engine checker
// Port-level assertions on the edit distance engine, attached by bind.
// ============================================================================
module ede_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input ede_pkg::in_item_t  in_item,
  input logic               out_valid,
  input logic               out_ready,
  input ede_pkg::out_item_t out_item
);

  // A result that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // The distance never exceeds the store capacity.
  a_dist_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.distance <= ede_pkg::DIST_W'(ede_pkg::MAX_LEN))
    else $error("distance out of range");

  // Reset empties the output register.
  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

  // A load or no-op item taken while no result is held never produces one.
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_item.command != ede_pkg::CMD_COMPUTE && !out_valid
    |=> !out_valid)
    else $error("result after a load item");

  // A compute item blocks the input in the next cycle.
  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_item.command == ede_pkg::CMD_COMPUTE |=> !in_ready)
    else $error("input ready right after a compute item");

endmodule

bind edit_distance_engine_core ede_checker u_ede_checker (.*);

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edit distance engine testbench
// Loads source and target strings one character per item and issues compute
// items. A built-in Levenshtein tracker predicts each distance and overflow
// flag, and every returned item is checked in order against it. Directed
// cases are followed by random string pairs under varying idle and stall
// patterns, including a long output stall and a full drain of results.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CODE_POINT_MAX = 1114111;
  localparam int DIST_LIMIT     = (1 << ede_pkg::DIST_W) - 1;
  localparam int CYCLE_LIMIT    = 1000000;
  localparam int TAIL_CYCLES    = 200;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  ede_pkg::in_item_t  in_item   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  ede_pkg::out_item_t out_item;

  // Tracked copy of the engine state.
  logic [ede_pkg::CHAR_BITS-1:0] src_text [ede_pkg::MAX_LEN];
  logic [ede_pkg::CHAR_BITS-1:0] tgt_text [ede_pkg::MAX_LEN];
  int                            src_len = 0;
  int                            tgt_len = 0;
  bit                            trunc_seen = 1'b0;
  ede_pkg::out_item_t            expected_results [$];

  int err_cnt         = 0;
  int items_sent      = 0;
  int cycle_cnt       = 0;
  int send_idle_pct   = 0;
  int recv_idle_pct   = 0;
  int ready_hold_left = 0;

  edit_distance_engine_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always #6 clk = ~clk;

  // Two-row Levenshtein recurrence over the tracked strings.
  function automatic int pair_distance();
    int prev_row [ede_pkg::MAX_LEN+1];
    int cur_row  [ede_pkg::MAX_LEN+1];
    int best;
    int cost;
    if (src_len == 0) return tgt_len;
    if (tgt_len == 0) return src_len;
    for (int j = 0; j <= tgt_len; j++) prev_row[j] = j;
    for (int i = 0; i < src_len; i++) begin
      cur_row[0] = i + 1;
      for (int j = 0; j < tgt_len; j++) begin
        cost = (src_text[i] == tgt_text[j]) ? 0 : 1;
        best = cur_row[j] + 1;
        if (prev_row[j+1] + 1 < best) best = prev_row[j+1] + 1;
        if (prev_row[j] + cost < best) best = prev_row[j] + cost;
        cur_row[j+1] = best;
      end
      prev_row = cur_row;
    end
    return prev_row[tgt_len];
  endfunction

  // Update the tracked state for one accepted item.
  function automatic void track_item(input ede_pkg::in_item_t it);
    ede_pkg::out_item_t r;
    int                 d;
    case (it.command)
      ede_pkg::CMD_SRC: begin
        if (src_len < ede_pkg::MAX_LEN) begin
          src_text[src_len] = it.char_code;
          src_len++;
        end else begin
          trunc_seen = 1'b1;
        end
      end
      ede_pkg::CMD_TGT: begin
        if (tgt_len < ede_pkg::MAX_LEN) begin
          tgt_text[tgt_len] = it.char_code;
          tgt_len++;
        end else begin
          trunc_seen = 1'b1;
        end
      end
      ede_pkg::CMD_COMPUTE: begin
        d = pair_distance();
        if (d > DIST_LIMIT) d = DIST_LIMIT;
        r.distance = d[ede_pkg::DIST_W-1:0];
        r.overflow = trunc_seen;
        expected_results.push_back(r);
        src_len    = 0;
        tgt_len    = 0;
        trunc_seen = 1'b0;
      end
      default: ;
    endcase
  endfunction

  // Compare one returned item with the oldest expectation.
  function automatic void check_result(input ede_pkg::out_item_t got);
    ede_pkg::out_item_t want;
    if (expected_results.size() == 0) begin
      $error("unexpected result: distance %0d, overflow %0d", got.distance, got.overflow);
      err_cnt++;
      return;
    end
    want = expected_results.pop_front();
    if (got.distance !== want.distance) begin
      $error("distance mismatch: expected %0d, actual %0d", want.distance, got.distance);
      err_cnt++;
    end
    if (got.overflow !== want.overflow) begin
      $error("overflow mismatch: expected %0d, actual %0d", want.overflow, got.overflow);
      err_cnt++;
    end
  endfunction

  // Both channels are sampled at the edge, before any driver update lands.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) track_item(in_item);
      if (out_valid && out_ready) check_result(out_item);
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  initial begin
    forever begin
      @(posedge clk);
      if (ready_hold_left > 0) begin
        out_ready <= 1'b0;
        ready_hold_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog.
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // Offer one item after a random idle gap and hold it until it is taken.
  task automatic send_item(input logic [ede_pkg::CMD_W-1:0]     cmd,
                           input logic [ede_pkg::CHAR_BITS-1:0] code);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_item.command   <= cmd;
    in_item.char_code <= code;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (cmd != ede_pkg::CMD_NOP) items_sent++;
  endtask

  // Stop offering items until every expected result has come back. It waits for
  // the next edge first so that an item accepted at this edge is already tracked.
  task automatic wait_for_all_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // A character from a narrow window above base, or anywhere when alpha is 0.
  function automatic logic [ede_pkg::CHAR_BITS-1:0] pick_char(input int base,
                                                              input int alpha);
    if (alpha == 0) return ede_pkg::CHAR_BITS'($urandom_range(0, CODE_POINT_MAX));
    return ede_pkg::CHAR_BITS'(base + $urandom_range(0, alpha - 1));
  endfunction

  // Load a source and a target string in random interleaving, then compute.
  // A related target copies the source with a small shift and some edits.
  task automatic send_string_pair(input int ns, input int nt, input bit related,
                                  input bit with_nops);
    logic [ede_pkg::CHAR_BITS-1:0] s_chars [$];
    logic [ede_pkg::CHAR_BITS-1:0] t_chars [$];
    int base;
    int alpha;
    int shift;
    int si;
    int ti;
    base  = $urandom_range(0, CODE_POINT_MAX - 8);
    alpha = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 4) : 0;
    shift = $urandom_range(0, 2);
    for (int i = 0; i < ns; i++) s_chars.push_back(pick_char(base, alpha));
    for (int j = 0; j < nt; j++) begin
      if (related && (j + shift < ns) && ($urandom_range(0, 3) != 0))
        t_chars.push_back(s_chars[j + shift]);
      else
        t_chars.push_back(pick_char(base, alpha));
    end
    si = 0;
    ti = 0;
    while (si < ns || ti < nt) begin
      if (with_nops && $urandom_range(0, 19) == 0)
        send_item(ede_pkg::CMD_NOP,
                  ede_pkg::CHAR_BITS'($urandom_range(0, CODE_POINT_MAX)));
      if (ti >= nt || (si < ns && $urandom_range(0, 1) == 1)) begin
        send_item(ede_pkg::CMD_SRC, s_chars[si]);
        si++;
      end else begin
        send_item(ede_pkg::CMD_TGT, t_chars[ti]);
        ti++;
      end
    end
    send_item(ede_pkg::CMD_COMPUTE,
              ede_pkg::CHAR_BITS'($urandom_range(0, CODE_POINT_MAX)));
  endtask

  // Empty strings, code point extremes, the unused command and simple edits.
  task automatic test_directed_cases();
    send_item(ede_pkg::CMD_COMPUTE, '0);
    send_item(ede_pkg::CMD_SRC, ede_pkg::CHAR_BITS'(CODE_POINT_MAX));
    send_item(ede_pkg::CMD_COMPUTE, '0);
    send_item(ede_pkg::CMD_TGT, '0);
    send_item(ede_pkg::CMD_TGT, ede_pkg::CHAR_BITS'(CODE_POINT_MAX));
    send_item(ede_pkg::CMD_COMPUTE, ede_pkg::CHAR_BITS'(CODE_POINT_MAX));
    send_item(ede_pkg::CMD_SRC, '0);
    send_item(ede_pkg::CMD_SRC, ede_pkg::CHAR_BITS'(CODE_POINT_MAX));
    send_item(ede_pkg::CMD_NOP, ede_pkg::CHAR_BITS'(21'h01234));
    send_item(ede_pkg::CMD_TGT, ede_pkg::CHAR_BITS'(CODE_POINT_MAX));
    send_item(ede_pkg::CMD_TGT, '0);
    send_item(ede_pkg::CMD_COMPUTE, ede_pkg::CHAR_BITS'(CODE_POINT_MAX));
    send_item(ede_pkg::CMD_SRC, ede_pkg::CHAR_BITS'(21'h00041));
    send_item(ede_pkg::CMD_TGT, ede_pkg::CHAR_BITS'(21'h00041));
    send_item(ede_pkg::CMD_COMPUTE, '0);
    send_item(ede_pkg::CMD_NOP, ede_pkg::CHAR_BITS'(CODE_POINT_MAX));
    send_item(ede_pkg::CMD_COMPUTE, '0);
    send_item(ede_pkg::CMD_SRC, ede_pkg::CHAR_BITS'(21'h0F0000));
    send_item(ede_pkg::CMD_TGT, ede_pkg::CHAR_BITS'(21'h0F0001));
    send_item(ede_pkg::CMD_COMPUTE, '0);
  endtask

  // Full stores, overrun of either store, and the largest possible distance.
  task automatic test_store_limits();
    logic [ede_pkg::CHAR_BITS-1:0] a_code;
    send_string_pair(ede_pkg::MAX_LEN + 1, 3, 1'b1, 1'b0);
    a_code = ede_pkg::CHAR_BITS'($urandom_range(0, CODE_POINT_MAX));
    for (int i = 0; i < ede_pkg::MAX_LEN; i++) send_item(ede_pkg::CMD_SRC, a_code);
    for (int i = 0; i <= ede_pkg::MAX_LEN; i++)
      send_item(ede_pkg::CMD_TGT, a_code ^ ede_pkg::CHAR_BITS'(1));
    send_item(ede_pkg::CMD_COMPUTE, '0);
    send_string_pair(ede_pkg::MAX_LEN, ede_pkg::MAX_LEN, 1'b1, 1'b0);
    send_string_pair(2, 2, 1'b0, 1'b0);
  endtask

  // Mostly well-formed string pairs with random content, some raw noise.
  task automatic test_random_traffic(input int n_items);
    int start;
    int roll;
    int ns;
    int nt;
    start = items_sent;
    while (items_sent - start < n_items) begin
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
        repeat ($urandom_range(1, 6))
          send_item(ede_pkg::CMD_W'($urandom_range(0, 3)),
                    ede_pkg::CHAR_BITS'($urandom_range(0, CODE_POINT_MAX)));
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
          ns = $urandom_range(40, ede_pkg::MAX_LEN + 6);
          nt = $urandom_range(40, ede_pkg::MAX_LEN + 6);
        end else if (roll < 12) begin
          ns = ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(0, 8);
          nt = (ns != 0) ? 0 : $urandom_range(0, 8);
        end else begin
          ns = $urandom_range(0, 8);
          nt = $urandom_range(0, 8);
        end
        send_string_pair(ns, nt, $urandom_range(0, 1) == 1, $urandom_range(0, 3) == 0);
      end
    end
  endtask

  // Hold the output off for a long stretch while pairs keep coming, so the
  // engine fills up and stops taking items.
  task automatic test_output_backpressure();
    ready_hold_left = 600;
    repeat (5) send_string_pair(4, 4, 1'b1, 1'b0);
    wait_for_all_results();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_store_limits();
    wait_for_all_results();

    send_idle_pct = 23;
    recv_idle_pct = 47;
    test_random_traffic(430);
    test_output_backpressure();

    send_idle_pct = 47;
    recv_idle_pct = 23;
    test_random_traffic(430);
    wait_for_all_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(430);
    wait_for_all_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
